// ===== hdl/ecal_pkg.sv =====
`default_nettype none

package ecal_pkg;

  // Widths of the quotients produced by the front end.
  localparam int DAYS_W = 15;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;

  localparam logic [30:0] SECS_PER_DAY  = 31'd86400;
  localparam logic [30:0] SECS_PER_HOUR = 31'd3600;
  localparam logic [30:0] SECS_PER_MIN  = 31'd60;

  // Each divisor is a power of two times an odd part: 86400 = 128 * 675,
  // 3600 = 16 * 225 and 60 = 4 * 15. Once the power of two is shifted out, the
  // product with the rounded-up reciprocal of the odd part, shifted right, is the
  // exact quotient over the whole range of the shifted count.
  localparam logic [24:0] DAY_RECIP        = 25'd25451659;
  localparam int          DAY_RECIP_SHIFT  = 34;
  localparam logic [13:0] HOUR_RECIP       = 14'd9321;
  localparam int          HOUR_RECIP_SHIFT = 21;
  localparam logic [10:0] MIN_RECIP        = 11'd1093;
  localparam int          MIN_RECIP_SHIFT  = 14;

  localparam logic [10:0] BASE_YEAR      = 11'd1970;
  localparam logic [6:0]  CENTURY_START  = 7'd70;
  localparam logic [6:0]  CENTURY_LAST   = 7'd99;
  localparam logic [8:0]  QUAD_START     = 9'd370;
  localparam logic [8:0]  QUAD_LAST      = 9'd399;
  localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd4;
  localparam logic [8:0]  YEAR_DAYS      = 9'd365;
  localparam logic [8:0]  LEAP_YEAR_DAYS = 9'd366;
  localparam logic [8:0]  WEEKS_52_DAYS  = 9'd364;
  localparam logic [4:0]  WEEKS_4_DAYS   = 5'd28;

  localparam logic [3:0] MONTH_JAN = 4'd0;
  localparam logic [3:0] MONTH_FEB = 4'd1;
  localparam logic [3:0] MONTH_APR = 4'd3;
  localparam logic [3:0] MONTH_JUN = 4'd5;
  localparam logic [3:0] MONTH_SEP = 4'd8;
  localparam logic [3:0] MONTH_NOV = 4'd10;
  localparam logic [3:0] MONTH_DEC = 4'd11;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DAYS,
    F_HOURS,
    F_MINS,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_YEAR,
    B_MONTH,
    B_FINISH
  } back_state_t;

  // One split-up timestamp waiting between the front end and the back end.
  typedef struct packed {
    logic [DAYS_W-1:0] days;
    logic [HOUR_W-1:0] hours;
    logic [MIN_W-1:0]  minutes;
    logic [5:0]        seconds;
  } slot_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      case (month)
        MONTH_FEB: len = leap ? 5'd29 : 5'd28;
        MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
        default: len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // Sum of two weekday offsets, each below seven, folded back below seven.
  function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
    logic [3:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s >= 4'd7) begin
        s = s - 4'd7;
      end
      return s[2:0];
    end
  endfunction

  // Remainder by seven of a value below forty-two.
  function automatic logic [2:0] mod7_small(input logic [5:0] v);
    logic [5:0] r;
    begin
      r = v;
      for (int i = 0; i < 5; i++) begin
        if (r >= 6'd7) begin
          r = r - 6'd7;
        end
      end
      return r[2:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ecal_front.sv =====
`default_nettype none

module ecal_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          time_valid,
  output logic               time_stall,
  input  wire logic [30:0]   epoch_seconds,
  output logic               push_valid,
  input  wire logic          push_stall,
  output ecal_pkg::slot_t    push_slot
);

  ecal_pkg::front_state_t state, state_next;

  logic [30:0] acc;
  logic [ecal_pkg::DAYS_W-1:0] quo;
  logic        step;
  logic [ecal_pkg::DAYS_W-1:0] days;
  logic [ecal_pkg::HOUR_W-1:0] hours;
  logic [ecal_pkg::MIN_W-1:0]  minutes;

  logic [48:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [30:0] quo_back;

  // Quotient estimates from the count with the divisor's power of two shifted out.
  assign day_prod  = {25'b0, acc[30:7]} * {24'b0, ecal_pkg::DAY_RECIP};
  assign hour_prod = {14'b0, acc[16:4]} * {13'b0, ecal_pkg::HOUR_RECIP};
  assign min_prod  = {11'b0, acc[11:2]} * {10'b0, ecal_pkg::MIN_RECIP};

  // The registered quotient times its divisor, taken back off the count.
  always_comb begin
    case (state)
      ecal_pkg::F_DAYS:
        quo_back = {{(31-ecal_pkg::DAYS_W){1'b0}}, quo} * ecal_pkg::SECS_PER_DAY;
      ecal_pkg::F_HOURS:
        quo_back = {{(31-ecal_pkg::HOUR_W){1'b0}}, quo[ecal_pkg::HOUR_W-1:0]}
                   * ecal_pkg::SECS_PER_HOUR;
      ecal_pkg::F_MINS:
        quo_back = {{(31-ecal_pkg::MIN_W){1'b0}}, quo[ecal_pkg::MIN_W-1:0]}
                   * ecal_pkg::SECS_PER_MIN;
      default:
        quo_back = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ecal_pkg::F_IDLE:  if (time_valid) state_next = ecal_pkg::F_DAYS;
      ecal_pkg::F_DAYS:  if (step == 1'b0) state_next = ecal_pkg::F_HOURS;
      ecal_pkg::F_HOURS: if (step == 1'b0) state_next = ecal_pkg::F_MINS;
      ecal_pkg::F_MINS:  if (step == 1'b0) state_next = ecal_pkg::F_PUSH;
      ecal_pkg::F_PUSH:  if (!push_stall) state_next = ecal_pkg::F_IDLE;
      default:           state_next = ecal_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    time_stall = (state != ecal_pkg::F_IDLE);
    push_valid = (state == ecal_pkg::F_PUSH);
    push_slot  = '{days: days, hours: hours, minutes: minutes, seconds: acc[5:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ecal_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Each split first registers the quotient, then removes it from the count.
  always_ff @(posedge clk) begin
    case (state)
      ecal_pkg::F_IDLE: begin
        if (time_valid) begin
          acc  <= epoch_seconds;
          step <= 1'b1;
        end
      end
      ecal_pkg::F_DAYS: begin
        if (step) begin
          quo  <= day_prod[ecal_pkg::DAY_RECIP_SHIFT +: ecal_pkg::DAYS_W];
          step <= 1'b0;
        end else begin
          acc  <= acc - quo_back;
          days <= quo;
          step <= 1'b1;
        end
      end
      ecal_pkg::F_HOURS: begin
        if (step) begin
          quo  <= {{(ecal_pkg::DAYS_W-ecal_pkg::HOUR_W){1'b0}},
                   hour_prod[ecal_pkg::HOUR_RECIP_SHIFT +: ecal_pkg::HOUR_W]};
          step <= 1'b0;
        end else begin
          acc   <= acc - quo_back;
          hours <= quo[ecal_pkg::HOUR_W-1:0];
          step  <= 1'b1;
        end
      end
      ecal_pkg::F_MINS: begin
        if (step) begin
          quo  <= {{(ecal_pkg::DAYS_W-ecal_pkg::MIN_W){1'b0}},
                   min_prod[ecal_pkg::MIN_RECIP_SHIFT +: ecal_pkg::MIN_W]};
          step <= 1'b0;
        end else begin
          acc     <= acc - quo_back;
          minutes <= quo[ecal_pkg::MIN_W-1:0];
          step    <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/ecal_queue.sv =====
`default_nettype none

module ecal_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  output logic                 push_stall,
  input  wire ecal_pkg::slot_t push_slot,
  output logic                 pop_valid,
  input  wire logic            pop_stall,
  output ecal_pkg::slot_t      pop_slot
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ecal_pkg::slot_t slots [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign push_stall = (count == CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_slot   = slots[rd_ptr];
  assign do_push    = push_valid && !push_stall;
  assign do_pop     = pop_valid && !pop_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_slot;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ecal_back.sv =====
`default_nettype none

module ecal_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  output logic                 pop_stall,
  input  wire ecal_pkg::slot_t pop_slot,
  output logic                 date_valid,
  input  wire logic            date_stall,
  output logic [5:0]           sec_of_min,
  output logic [5:0]           min_of_hour,
  output logic [4:0]           hour_of_day,
  output logic [2:0]           weekday,
  output logic [4:0]           day_of_month,
  output logic [3:0]           month_num,
  output logic [10:0]          year_num
);

  ecal_pkg::back_state_t state, state_next;

  logic [ecal_pkg::DAYS_W-1:0] days_acc;
  logic [10:0] year;
  logic [6:0]  cent;
  logic [8:0]  quad;
  logic [3:0]  month_idx;
  logic [2:0]  wd;
  logic [ecal_pkg::HOUR_W-1:0] hours;
  logic [ecal_pkg::MIN_W-1:0]  minutes;
  logic [5:0]  seconds;

  logic       leap;
  logic [8:0] ylen;
  logic [4:0] mlen;
  logic       year_done;
  logic       month_done;
  logic       out_free;

  // The century counters give the Gregorian exceptions without any divider.
  assign leap       = (cent == '0) ? (quad == '0) : (year[1:0] == 2'b00);
  assign ylen       = leap ? ecal_pkg::LEAP_YEAR_DAYS : ecal_pkg::YEAR_DAYS;
  assign mlen       = ecal_pkg::month_len(month_idx, leap);
  assign year_done  = days_acc < {{(ecal_pkg::DAYS_W-9){1'b0}}, ylen};
  assign month_done = (month_idx == ecal_pkg::MONTH_DEC)
                      || (days_acc < {{(ecal_pkg::DAYS_W-5){1'b0}}, mlen});
  assign out_free   = !date_valid || !date_stall;

  always_comb begin
    state_next = state;
    case (state)
      ecal_pkg::B_IDLE:   if (pop_valid) state_next = ecal_pkg::B_YEAR;
      ecal_pkg::B_YEAR:   if (year_done) state_next = ecal_pkg::B_MONTH;
      ecal_pkg::B_MONTH:  if (month_done) state_next = ecal_pkg::B_FINISH;
      ecal_pkg::B_FINISH: if (out_free) state_next = ecal_pkg::B_IDLE;
      default:            state_next = ecal_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop_stall = (state != ecal_pkg::B_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ecal_pkg::B_IDLE;
      date_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ecal_pkg::B_FINISH && out_free) begin
        date_valid <= 1'b1;
      end else if (!date_stall) begin
        date_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ecal_pkg::B_IDLE: begin
        if (pop_valid) begin
          days_acc <= pop_slot.days;
          hours    <= pop_slot.hours;
          minutes  <= pop_slot.minutes;
          seconds  <= pop_slot.seconds;
          year     <= ecal_pkg::BASE_YEAR;
          cent     <= ecal_pkg::CENTURY_START;
          quad     <= ecal_pkg::QUAD_START;
          wd       <= ecal_pkg::EPOCH_WEEKDAY;
        end
      end
      ecal_pkg::B_YEAR: begin
        if (year_done) begin
          month_idx <= ecal_pkg::MONTH_JAN;
        end else begin
          days_acc <= days_acc - {{(ecal_pkg::DAYS_W-9){1'b0}}, ylen};
          year     <= year + 11'd1;
          cent     <= (cent == ecal_pkg::CENTURY_LAST) ? '0 : cent + 7'd1;
          quad     <= (quad == ecal_pkg::QUAD_LAST) ? '0 : quad + 9'd1;
          // A year moves the weekday on by its length beyond whole weeks.
          wd       <= ecal_pkg::add_mod7(wd, 3'(ylen - ecal_pkg::WEEKS_52_DAYS));
        end
      end
      ecal_pkg::B_MONTH: begin
        if (!month_done) begin
          days_acc  <= days_acc - {{(ecal_pkg::DAYS_W-5){1'b0}}, mlen};
          month_idx <= month_idx + 4'd1;
          wd        <= ecal_pkg::add_mod7(wd, 3'(mlen - ecal_pkg::WEEKS_4_DAYS));
        end
      end
      ecal_pkg::B_FINISH: begin
        if (out_free) begin
          sec_of_min   <= seconds;
          min_of_hour  <= minutes;
          hour_of_day  <= hours;
          weekday      <= ecal_pkg::mod7_small({3'b000, wd} + {1'b0, days_acc[4:0]});
          day_of_month <= days_acc[4:0] + 5'd1;
          month_num    <= month_idx + 4'd1;
          year_num     <= year;
        end
      end
      default: begin
      end
    endcase
  end

  a_weekday_range: assert property (@(posedge clk) disable iff (rst)
    (state != ecal_pkg::B_IDLE) |-> (wd < 3'd7))
    else $error("weekday offset left its range");

  a_century_phase: assert property (@(posedge clk) disable iff (rst)
    (state != ecal_pkg::B_IDLE) |-> (cent[1:0] == year[1:0]))
    else $error("century counter out of step with the year");

  a_month_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ecal_pkg::B_MONTH)
    |-> (days_acc < {{(ecal_pkg::DAYS_W-9){1'b0}}, ecal_pkg::LEAP_YEAR_DAYS})
        && (month_idx <= ecal_pkg::MONTH_DEC))
    else $error("month walk started with more than a year of days");

  a_day_fits: assert property (@(posedge clk) disable iff (rst)
    (state == ecal_pkg::B_FINISH) |-> (days_acc < {{(ecal_pkg::DAYS_W-5){1'b0}}, 5'd31}))
    else $error("day of month overflow");

endmodule

`default_nettype wire

// ===== hdl/epoch_seconds_to_calendar.sv =====
// A time transfer passes through the front end, a slot of the queue and the back end before
// its date transfer. The back end takes a new timestamp only once it has finished the last:
// its walk takes year lengths, then month lengths, off the day count, so it runs longer,
// and items pass more slowly, for later years and months. The front end likewise takes a
// new time only once it has pushed the last.
// Reset (rst, synchronous, active high) empties the queue, idles both halves and drops
// any pending result; no clearing pass is needed.
`default_nettype none

module epoch_seconds_to_calendar #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        time_valid,
  output logic             time_stall,
  input  wire logic [30:0] epoch_seconds,
  output logic             date_valid,
  input  wire logic        date_stall,
  output logic [5:0]       sec_of_min,
  output logic [5:0]       min_of_hour,
  output logic [4:0]       hour_of_day,
  output logic [2:0]       weekday,
  output logic [4:0]       day_of_month,
  output logic [3:0]       month_num,
  output logic [10:0]      year_num
);

  // The front end splits the count into whole days and the time of day by
  // reciprocal multiplication: for the day, the hour and the minute in turn, the
  // quotient is registered and taken back off the count in the cycle after, the
  // final remainder being the second. Each split timestamp is then a transfer
  // into a short queue.
  logic            push_valid;
  logic            push_stall;
  ecal_pkg::slot_t push_slot;

  // The back end pulls from the queue and walks the day count year by year, then
  // month by month, tracking the weekday as it goes so that no modulo of the full
  // day count is needed. Its result register lets the next item begin while the
  // previous result still waits for its transfer.
  logic            pop_valid;
  logic            pop_stall;
  ecal_pkg::slot_t pop_slot;

  ecal_front u_front (
    .clk           (clk),
    .rst           (rst),
    .time_valid    (time_valid),
    .time_stall    (time_stall),
    .epoch_seconds (epoch_seconds),
    .push_valid    (push_valid),
    .push_stall    (push_stall),
    .push_slot     (push_slot)
  );

  ecal_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_slot  (push_slot),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_slot   (pop_slot)
  );

  ecal_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_stall    (pop_stall),
    .pop_slot     (pop_slot),
    .date_valid   (date_valid),
    .date_stall   (date_stall),
    .sec_of_min   (sec_of_min),
    .min_of_hour  (min_of_hour),
    .hour_of_day  (hour_of_day),
    .weekday      (weekday),
    .day_of_month (day_of_month),
    .month_num    (month_num),
    .year_num     (year_num)
  );

endmodule

`default_nettype wire
